[hdl/rbox_pkg.sv]
`default_nettype none
package rbox_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int T_WIDTH     = 32;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    // The quotient is saturated at 2^32, so it needs 33 bits.
    localparam int Q_WIDTH     = 33;
    // One restoring step per numerator bit plus 16 fraction bits.
    localparam int DIV_STEPS   = DIFF_WIDTH + 16;
    localparam int FACE_WIDTH  = 3;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_X  = 3'd0,
        REG_LOW_Y  = 3'd1,
        REG_LOW_Z  = 3'd2,
        REG_HIGH_X = 3'd3,
        REG_HIGH_Y = 3'd4,
        REG_HIGH_Z = 3'd5
    } t_cfg_idx;

    typedef enum logic [FACE_WIDTH-1:0] {
        FACE_NX = 3'd0,
        FACE_NY = 3'd1,
        FACE_NZ = 3'd2,
        FACE_PX = 3'd3,
        FACE_PY = 3'd4,
        FACE_PZ = 3'd5
    } t_face;

    localparam logic signed [T_WIDTH-1:0] T_POS_MAX = {1'b0, {(T_WIDTH-1){1'b1}}};
    localparam logic signed [T_WIDTH-1:0] T_NEG_MAX = {1'b1, {(T_WIDTH-1){1'b0}}};

    // One division lane state as it moves through the divider stages.
    typedef struct packed {
        logic [DIFF_WIDTH-1:0] num;
        logic [COORD_WIDTH:0]  den;
        logic [DIFF_WIDTH:0]   rem;
        logic [Q_WIDTH-1:0]    quo;
        logic                  neg;
        logic                  zden;
        logic                  nzero;
    } t_div;
endpackage
`default_nettype wire

[hdl/rbox_div_step.sv]
`default_nettype none
// One register stage of the restoring divider: up to eight quotient bits per lane.
module rbox_div_step (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [6:0]       i_first,
    input  rbox_pkg::t_div        i_lane [6],
    output rbox_pkg::t_div        o_lane [6]
);
    import rbox_pkg::*;

    t_div n_lane [6];
    t_div r_lane [6];

    always_comb begin
        for (int l = 0; l < 6; l++) begin
            n_lane[l] = i_lane[l];
            for (int k = 0; k < 8; k++) begin
                logic [6:0] idx;
                logic [6:0] bi;
                logic       nb;
                logic [DIFF_WIDTH:0] sh;
                logic [Q_WIDTH:0]    qs;
                idx = i_first - 7'(k);
                bi  = idx - 7'd16;
                // Numerator bits come first, then sixteen zero fraction bits.
                nb  = (idx >= 7'd16 && idx < 7'(DIFF_WIDTH + 16)) ?
                      n_lane[l].num[bi[5:0]] : 1'b0;
                if (i_first < 7'(k) || i_first - 7'(k) >= 7'(DIV_STEPS)) begin
                    nb = 1'b0;
                end
                sh = {n_lane[l].rem[DIFF_WIDTH-1:0], nb};
                if (!(i_first < 7'(k))) begin
                    if (sh >= {1'b0, n_lane[l].den}) begin
                        n_lane[l].rem = sh - {1'b0, n_lane[l].den};
                        qs = {n_lane[l].quo, 1'b1};
                    end else begin
                        n_lane[l].rem = sh;
                        qs = {n_lane[l].quo, 1'b0};
                    end
                    // The quotient sticks at 2^32 once it gets there.
                    if (qs > {2'b01, {(Q_WIDTH-1){1'b0}}}) begin
                        n_lane[l].quo = {1'b1, {(Q_WIDTH-1){1'b0}}};
                    end else begin
                        n_lane[l].quo = qs[Q_WIDTH-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule
`default_nettype wire

[hdl/rbox_select.sv]
`default_nettype none
// Final stage logic: saturate the quotients, pick entry and exit, decide the hit.
module rbox_select (
    input  rbox_pkg::t_div         i_lane [6],
    input  wire logic [2:0]        i_dneg,
    output logic                   o_hit,
    output logic [30:0]            o_hit_t,
    output logic [2:0]             o_hit_face
);
    import rbox_pkg::*;

    logic signed [T_WIDTH-1:0] t [6];
    logic signed [T_WIDTH-1:0] tin, tout, tsel;
    logic [2:0] fin, fout;

    always_comb begin
        for (int l = 0; l < 6; l++) begin
            if (i_lane[l].zden) begin
                if (i_lane[l].nzero)   t[l] = '0;
                else if (i_lane[l].neg) t[l] = T_NEG_MAX;
                else                    t[l] = T_POS_MAX;
            end else if (i_lane[l].neg) begin
                if (i_lane[l].quo >= {1'b0, 1'b1, {(Q_WIDTH-2){1'b0}}})
                    t[l] = T_NEG_MAX;
                else
                    t[l] = -$signed({1'b0, i_lane[l].quo[T_WIDTH-2:0]});
            end else begin
                if (i_lane[l].quo > {2'b00, {(Q_WIDTH-2){1'b1}}})
                    t[l] = T_POS_MAX;
                else
                    t[l] = $signed({1'b0, i_lane[l].quo[T_WIDTH-2:0]});
            end
        end
        // Lanes 0..2 are entry t per axis, lanes 3..5 exit t.
        if (t[0] > t[1]) begin
            tin = t[0]; fin = i_dneg[0] ? FACE_PX : FACE_NX;
        end else begin
            tin = t[1]; fin = i_dneg[1] ? FACE_PY : FACE_NY;
        end
        if (t[2] > tin) begin
            tin = t[2]; fin = i_dneg[2] ? FACE_PZ : FACE_NZ;
        end
        if (t[3] < t[4]) begin
            tout = t[3]; fout = i_dneg[0] ? FACE_NX : FACE_PX;
        end else begin
            tout = t[4]; fout = i_dneg[1] ? FACE_NY : FACE_PY;
        end
        if (t[5] < tout) begin
            tout = t[5]; fout = i_dneg[2] ? FACE_NZ : FACE_PZ;
        end
        tsel = (tin > 0) ? tin : tout;
        o_hit = (tin < tout) && (tout > 0);
        o_hit_t    = o_hit ? tsel[30:0] : '0;
        o_hit_face = o_hit ? ((tin > 0) ? fin : fout) : '0;
    end
endmodule
`default_nettype wire

[hdl/ray_box_slab_hit_test_core.sv]
`default_nettype none
// Ray versus axis-aligned box hit test, slab method, signed Q16.16 throughout.
// The box is six configuration registers; each ray is one input item and
// gives one result item. The block is a fully pipelined restoring divider:
// one setup stage forms the six slab numerators, seven divider stages each
// retire up to eight quotient bits for all six slabs in parallel, and a last
// stage picks entry and exit and registers the result. One item enters per
// clock while not stalled; each result passes the setup, divider and output
// registers in turn. The whole pipeline advances when the output register is
// free or being taken, so a stall holds every stage in place.
module ray_box_slab_hit_test_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [2:0]                       i_cfg_idx,
    input  wire logic [rbox_pkg::COORD_WIDTH-1:0] i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic signed [rbox_pkg::COORD_WIDTH-1:0] i_origin_x,
    input  wire logic signed [rbox_pkg::COORD_WIDTH-1:0] i_origin_y,
    input  wire logic signed [rbox_pkg::COORD_WIDTH-1:0] i_origin_z,
    input  wire logic signed [rbox_pkg::COORD_WIDTH-1:0] i_dir_x,
    input  wire logic signed [rbox_pkg::COORD_WIDTH-1:0] i_dir_y,
    input  wire logic signed [rbox_pkg::COORD_WIDTH-1:0] i_dir_z,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic                                  o_hit,
    output logic [30:0]                           o_hit_t,
    output logic [2:0]                            o_hit_face
);
    import rbox_pkg::*;

    localparam int NDIV = (DIV_STEPS + 7) / 8;

    logic signed [COORD_WIDTH-1:0] r_lo [3];
    logic signed [COORD_WIDTH-1:0] r_hi [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LOW_X:  r_lo[0] <= i_cfg_data;
                REG_LOW_Y:  r_lo[1] <= i_cfg_data;
                REG_LOW_Z:  r_lo[2] <= i_cfg_data;
                REG_HIGH_X: r_hi[0] <= i_cfg_data;
                REG_HIGH_Y: r_hi[1] <= i_cfg_data;
                REG_HIGH_Z: r_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advance: everything moves when the output slot frees up.
    logic adv;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // Setup stage: sort bounds, form numerators and divisor magnitudes.
    logic signed [COORD_WIDTH-1:0] org [3];
    logic signed [COORD_WIDTH-1:0] dir [3];
    t_div n_setup [6];
    logic [2:0] n_dneg;

    assign org[0] = i_origin_x;
    assign org[1] = i_origin_y;
    assign org[2] = i_origin_z;
    assign dir[0] = i_dir_x;
    assign dir[1] = i_dir_y;
    assign dir[2] = i_dir_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic signed [COORD_WIDTH-1:0] lo, hi, bin, bout;
            logic signed [DIFF_WIDTH-1:0] din, dout;
            logic [COORD_WIDTH:0] dext;
            logic dn;
            lo   = (r_hi[a] < r_lo[a]) ? r_hi[a] : r_lo[a];
            hi   = (r_hi[a] < r_lo[a]) ? r_lo[a] : r_hi[a];
            dn   = dir[a][COORD_WIDTH-1];
            dext = {dir[a][COORD_WIDTH-1], dir[a]};
            bin  = dn ? hi : lo;
            bout = dn ? lo : hi;
            din  = DIFF_WIDTH'(bin) - DIFF_WIDTH'(org[a]);
            dout = DIFF_WIDTH'(bout) - DIFF_WIDTH'(org[a]);
            n_dneg[a] = dn;
            n_setup[a].num   = din[DIFF_WIDTH-1] ? DIFF_WIDTH'(-din) : din;
            n_setup[a].neg   = din[DIFF_WIDTH-1] ^ dn;
            n_setup[a].nzero = (din == '0);
            n_setup[a+3].num   = dout[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dout) : dout;
            n_setup[a+3].neg   = dout[DIFF_WIDTH-1] ^ dn;
            n_setup[a+3].nzero = (dout == '0);
            for (int s = 0; s < 2; s++) begin
                n_setup[a+3*s].den  = dn ? (COORD_WIDTH+1)'(-dext) : dext;
                n_setup[a+3*s].zden = (dir[a] == '0);
                n_setup[a+3*s].rem  = '0;
                n_setup[a+3*s].quo  = '0;
            end
            // A zero divisor's sign follows the numerator alone.
            if (dir[a] == '0) begin
                n_setup[a].neg   = din[DIFF_WIDTH-1];
                n_setup[a+3].neg = dout[DIFF_WIDTH-1];
            end
        end
    end

    t_div r_setup [6];
    logic [NDIV+1:0] r_vld;
    logic [2:0]    r_dneg [NDIV+1];
    t_div          lanes [NDIV+1][6];

    // One valid bit per register stage, the output register included.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NDIV:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_setup   <= n_setup;
            r_dneg[0] <= n_dneg;
            for (int s = 1; s <= NDIV; s++) r_dneg[s] <= r_dneg[s-1];
        end
    end

    assign lanes[0] = r_setup;

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        rbox_div_step u_step (
            .i_clk   (i_clk),
            .i_en    (adv),
            .i_first (7'(DIV_STEPS - 1 - 8 * g)),
            .i_lane  (lanes[g]),
            .o_lane  (lanes[g+1])
        );
    end

    logic        s_hit;
    logic [30:0] s_t;
    logic [2:0]  s_face;

    rbox_select u_sel (
        .i_lane     (lanes[NDIV]),
        .i_dneg     (r_dneg[NDIV]),
        .o_hit      (s_hit),
        .o_hit_t    (s_t),
        .o_hit_face (s_face)
    );

    logic        r_hit;
    logic [30:0] r_t;
    logic [2:0]  r_face;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hit  <= s_hit;
            r_t    <= s_t;
            r_face <= s_face;
        end
    end

    assign o_valid    = r_vld[NDIV+1];
    assign o_hit      = r_hit;
    assign o_hit_t    = r_t;
    assign o_hit_face = r_face;
endmodule
`default_nettype wire

[hdl/rbox_checker.sv]
`default_nettype none
module rbox_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_hit,
    input wire logic [30:0] o_hit_t,
    input wire logic [2:0]  o_hit_face
);
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_hit_t == 31'd0 && o_hit_face == 3'd0))
        else $error("miss with nonzero fields");
    a_hit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_hit_t != 31'd0))
        else $error("hit at zero t");
    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit_face <= 3'd5))
        else $error("face out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_hit_t) && $stable(o_hit)))
        else $error("stalled result changed");
endmodule

bind ray_box_slab_hit_test_core rbox_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_hit(o_hit), .o_hit_t(o_hit_t), .o_hit_face(o_hit_face)
);
`default_nettype wire
